[src/udpps_pkg.sv]
// ----------------------------------------------------------------------------
// udpps_pkg
// Shared constants and types for the UDP destination port packet steer.
// ----------------------------------------------------------------------------
package udpps_pkg;

    localparam int unsigned OFF_W = 7;

    localparam logic [OFF_W-1:0] OFF_MAX      = 7'd127;
    localparam logic [OFF_W-1:0] OFF_ETYPE_HI = 7'd12;
    localparam logic [OFF_W-1:0] OFF_ETYPE_LO = 7'd13;
    localparam logic [OFF_W-1:0] ETH_HDR_LEN  = 7'd14;
    localparam logic [OFF_W-1:0] OFF_V4_PROTO = 7'd23;
    localparam logic [OFF_W-1:0] OFF_V6_NHDR  = 7'd20;
    localparam logic [OFF_W-1:0] V6_UDP_START = 7'd54;

    localparam logic [7:0] V4_MIN_LEN  = 8'd34;
    localparam logic [7:0] V6_MIN_LEN  = 8'd62;
    localparam logic [7:0] UDP_HDR_LEN = 8'd8;

    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6   = 16'h86DD;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [15:0] DEFAULT_PORT = 16'd3478;

    typedef enum logic {
        ACT_PASS     = 1'b0,
        ACT_REDIRECT = 1'b1
    } t_action;

    // verdict handed from the parser to the result register
    typedef struct packed {
        logic    valid;
        t_action action;
    } t_verdict;

endpackage

[src/udpps_cfg.sv]
// ----------------------------------------------------------------------------
// udpps_cfg
// Target port register, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module udpps_cfg
    import udpps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic [15:0] o_steer_port
);

    logic [15:0] r_steer_port;

    assign o_cfg_ready  = 1'b1;
    assign o_steer_port = r_steer_port;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steer_port <= DEFAULT_PORT;
        end else if (i_cfg_valid) begin
            r_steer_port <= i_cfg_data;
        end
    end

endmodule

[src/udpps_parse.sv]
// ----------------------------------------------------------------------------
// udpps_parse
// Byte offset counter, header field capture and end-of-frame verdict.
// ----------------------------------------------------------------------------
module udpps_parse
    import udpps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_steer_port,
    output t_verdict    o_verdict
);

    logic [OFF_W-1:0] r_offset;
    logic [15:0]      r_ether;
    logic [3:0]       r_ihl;
    logic [7:0]       r_proto;
    logic [15:0]      r_port;

    logic [15:0]      n_ether;
    logic [3:0]       n_ihl;
    logic [7:0]       n_proto;
    logic [15:0]      n_port;
    logic [OFF_W-1:0] udp_start;
    logic [7:0]       frame_len;
    logic             hit;

    always_comb begin
        n_ether = r_ether;
        if (r_offset == OFF_ETYPE_HI) begin
            n_ether[15:8] = i_frame_byte;
        end else if (r_offset == OFF_ETYPE_LO) begin
            n_ether[7:0] = i_frame_byte;
        end

        n_ihl   = r_ihl;
        n_proto = r_proto;
        if (n_ether == ETYPE_IPV4) begin
            if (r_offset == ETH_HDR_LEN) begin
                n_ihl = i_frame_byte[3:0];
            end
            if (r_offset == OFF_V4_PROTO) begin
                n_proto = i_frame_byte;
            end
        end else if (n_ether == ETYPE_IPV6) begin
            if (r_offset == OFF_V6_NHDR) begin
                n_proto = i_frame_byte;
            end
        end

        // IHL is taken as is, even below five words
        if (n_ether == ETYPE_IPV6) begin
            udp_start = V6_UDP_START;
        end else begin
            udp_start = ETH_HDR_LEN + {1'b0, n_ihl, 2'b00};
        end

        n_port = r_port;
        if (r_offset >= ETH_HDR_LEN) begin
            if (r_offset == udp_start + 7'd2) begin
                n_port[15:8] = i_frame_byte;
            end else if (r_offset == udp_start + 7'd3) begin
                n_port[7:0] = i_frame_byte;
            end
        end

        frame_len = {1'b0, r_offset} + 8'd1;
        hit = 1'b0;
        if (n_ether == ETYPE_IPV4) begin
            hit = (n_proto == PROTO_UDP) && (frame_len >= V4_MIN_LEN)
                && (frame_len >= {1'b0, udp_start} + UDP_HDR_LEN)
                && (n_port == i_steer_port);
        end else if (n_ether == ETYPE_IPV6) begin
            hit = (n_proto == PROTO_UDP) && (frame_len >= V6_MIN_LEN)
                && (n_port == i_steer_port);
        end

        o_verdict.valid  = i_accept && i_last_byte;
        o_verdict.action = hit ? ACT_REDIRECT : ACT_PASS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_ether  <= '0;
            r_ihl    <= '0;
            r_proto  <= '0;
            r_port   <= '0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                r_offset <= '0;
                r_ether  <= '0;
                r_ihl    <= '0;
                r_proto  <= '0;
                r_port   <= '0;
            end else begin
                r_offset <= (r_offset == OFF_MAX) ? OFF_MAX : r_offset + 7'd1;
                r_ether  <= n_ether;
                r_ihl    <= n_ihl;
                r_proto  <= n_proto;
                r_port   <= n_port;
            end
        end
    end

endmodule

[src/udpps_out.sv]
// ----------------------------------------------------------------------------
// udpps_out
// Result register holding one action until the downstream side takes it.
// ----------------------------------------------------------------------------
module udpps_out
    import udpps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_verdict i_verdict,
    output logic     o_room,
    output logic     o_valid,
    input  logic     i_ready,
    output logic     o_action
);

    logic    r_valid;
    t_action r_action;

    // room whenever the held result leaves in this cycle or none is held
    assign o_room   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_action = r_action;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_verdict.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_room && i_verdict.valid) begin
            r_action <= i_verdict.action;
        end
    end

endmodule

[src/udp_dest_port_packet_steer.sv]
// ----------------------------------------------------------------------------
// udp_dest_port_packet_steer
// Classifies Ethernet frames by UDP destination port, one byte per cycle.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle, i_last_byte marking the end of a frame, and
// gives one action per frame in the cycle after its last byte: redirect for an
// IPv4 or IPv6 UDP frame long enough to hold the UDP header whose destination
// port equals the target port (reset value 3478), pass for all others. Each
// byte is handled in the cycle it is accepted, so a new byte can enter
// every cycle; o_ready drops only while a result is held and not taken.
// VLAN tags and IPv6 extension headers are not followed. Write the target port
// only while no frame is in flight.
module udp_dest_port_packet_steer
    import udpps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_action
);

    logic [15:0] steer_port;
    logic        room;
    logic        accept;
    t_verdict    verdict;

    assign o_ready = room;
    assign accept  = i_valid && room;

    udpps_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_steer_port (steer_port)
    );

    udpps_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_frame_byte (i_frame_byte),
        .i_last_byte  (i_last_byte),
        .i_steer_port (steer_port),
        .o_verdict    (verdict)
    );

    udpps_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_verdict (verdict),
        .o_room    (room),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_action  (o_action)
    );

endmodule

[sim/udpps_steer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udpps_steer_checker
// Watches the steer block's channels, predicts each frame's action, compares.
// ----------------------------------------------------------------------------
// Tracks the target port through config transactions and parses every
// accepted frame byte the way the block should. Each last byte queues one
// expected action. Each accepted result is checked against the oldest one.
// Exposes the number of outstanding actions and the failure count.
module udpps_steer_checker
    import udpps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_byte_valid,
    input  logic        i_byte_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    input  logic        i_act_valid,
    input  logic        i_act_ready,
    input  logic        i_action,
    output int          o_pending,
    output int          o_fail_count
);

    logic [15:0]   redirect_port;
    logic [6:0]    frame_offset;
    logic [15:0]   seen_ethertype;
    logic [3:0]    seen_ihl;
    logic [7:0]    seen_proto;
    logic [15:0]   seen_dport;
    t_action       expected_actions[$];

    task automatic clear_frame();
        frame_offset   = '0;
        seen_ethertype = '0;
        seen_ihl       = '0;
        seen_proto     = '0;
        seen_dport     = '0;
    endtask

    task automatic flag_error(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // one accepted byte; on the last byte queue the frame's action
    task automatic predict_byte(input logic [7:0] b, input logic last);
        int  off;
        int  udp_at;
        int  frame_len;
        bit  hit;
        off = int'(frame_offset);
        if (off == int'(OFF_ETYPE_HI)) begin
            seen_ethertype[15:8] = b;
        end else if (off == int'(OFF_ETYPE_LO)) begin
            seen_ethertype[7:0] = b;
        end
        if (seen_ethertype == ETYPE_IPV4) begin
            if (off == int'(ETH_HDR_LEN)) seen_ihl = b[3:0];
            if (off == int'(OFF_V4_PROTO)) seen_proto = b;
        end else if (seen_ethertype == ETYPE_IPV6) begin
            if (off == int'(OFF_V6_NHDR)) seen_proto = b;
        end
        // IHL is taken as is, even below 5
        udp_at = (seen_ethertype == ETYPE_IPV6) ? int'(V6_UDP_START)
                                                : int'(ETH_HDR_LEN) + 4 * int'(seen_ihl);
        if (off >= int'(ETH_HDR_LEN)) begin
            if (off == udp_at + 2) begin
                seen_dport[15:8] = b;
            end else if (off == udp_at + 3) begin
                seen_dport[7:0] = b;
            end
        end
        if (last) begin
            frame_len = off + 1;
            hit = 1'b0;
            if (seen_ethertype == ETYPE_IPV4) begin
                hit = seen_proto == PROTO_UDP && frame_len >= int'(V4_MIN_LEN) &&
                      frame_len >= udp_at + int'(UDP_HDR_LEN) &&
                      seen_dport == redirect_port;
            end else if (seen_ethertype == ETYPE_IPV6) begin
                hit = seen_proto == PROTO_UDP && frame_len >= int'(V6_MIN_LEN) &&
                      seen_dport == redirect_port;
            end
            expected_actions.push_back(hit ? ACT_REDIRECT : ACT_PASS);
            clear_frame();
        end else if (frame_offset != OFF_MAX) begin
            frame_offset = frame_offset + 7'd1;
        end
    endtask

    always @(posedge i_clk) begin
        t_action want;
        if (!i_rst_n) begin
            redirect_port = DEFAULT_PORT;
            clear_frame();
            expected_actions.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                redirect_port = i_cfg_data;
            end
            if (i_byte_valid && i_byte_ready) begin
                predict_byte(i_frame_byte, i_last_byte);
            end
            if (i_act_valid && i_act_ready) begin
                if (expected_actions.size() == 0) begin
                    flag_error($sformatf("action %0d with none expected", i_action));
                end else begin
                    want = expected_actions.pop_front();
                    if (i_action !== want) begin
                        flag_error($sformatf("action expected %0d, got %0d", want, i_action));
                    end
                end
            end
        end
        o_pending = expected_actions.size();
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Frame stimulus and verdict for the UDP destination port packet steer.
// ----------------------------------------------------------------------------
// Sends directed frames at the reset target port, then several phases of
// random frames, each after a new target port write (zero, all ones, random,
// default, high bit). Most frames are well-formed IPv4/IPv6 UDP with the port
// often matching; the rest are short, non-UDP, non-IP, long or one-byte.
// Both sides idle in random bursts; the third and final phases run without idling.
module tb_top;
    import udpps_pkg::*;

    typedef enum int {
        FK_V4,
        FK_V6,
        FK_OTHER
    } t_frame_kind;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic [15:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic [7:0]  frame_byte = '0;
    logic        last_byte  = 1'b0;
    logic        out_ready  = 1'b0;
    logic        cfg_ready;
    logic        in_ready;
    logic        out_valid;
    logic        action;

    int          pending;
    int          fail_count;
    bit          gaps_on    = 1'b0;
    int          stall_left = 0;
    logic [15:0] target_now = DEFAULT_PORT;
    logic [7:0]  frame_buf[$];
    int          bytes_sent  = 0;
    int          frames_sent = 0;

    always #6 clk = ~clk;

    udp_dest_port_packet_steer u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_frame_byte (frame_byte),
        .i_last_byte  (last_byte),
        .o_valid      (out_valid),
        .i_ready      (out_ready),
        .o_action     (action)
    );

    udpps_steer_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_byte_valid (in_valid),
        .i_byte_ready (in_ready),
        .i_frame_byte (frame_byte),
        .i_last_byte  (last_byte),
        .i_act_valid  (out_valid),
        .i_act_ready  (out_ready),
        .i_action     (action),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // result side backpressure in random bursts
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 14);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic void set_byte(input int idx, input logic [7:0] v);
        if (idx < frame_buf.size()) frame_buf[idx] = v;
    endfunction

    task automatic make_frame(input t_frame_kind kind, input int len, input logic [3:0] ihl,
                              input logic [7:0] proto, input logic [15:0] dport);
        logic [7:0] b;
        int         udp_at;
        frame_buf.delete();
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            frame_buf.push_back(b);
        end
        if (kind == FK_V4) begin
            set_byte(12, ETYPE_IPV4[15:8]);
            set_byte(13, ETYPE_IPV4[7:0]);
            set_byte(14, {4'h4, ihl});
            set_byte(23, proto);
            udp_at = 14 + 4 * int'(ihl);
        end else if (kind == FK_V6) begin
            set_byte(12, ETYPE_IPV6[15:8]);
            set_byte(13, ETYPE_IPV6[7:0]);
            set_byte(20, proto);
            udp_at = int'(V6_UDP_START);
        end
        if (kind != FK_OTHER) begin
            set_byte(udp_at + 2, dport[15:8]);
            set_byte(udp_at + 3, dport[7:0]);
        end
    endtask

    task automatic random_frame();
        int          r;
        int          len;
        int          min_len;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] dport;
        t_frame_kind kind;
        r     = $urandom_range(0, 99);
        dport = ($urandom_range(0, 9) < 6) ? target_now : 16'($urandom);
        proto = ($urandom_range(0, 9) < 8) ? PROTO_UDP : 8'($urandom);
        ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
        if (r < 45) begin
            kind    = FK_V4;
            min_len = 14 + 4 * int'(ihl) + 8;
            if (min_len < 34) min_len = 34;
        end else if (r < 80) begin
            kind    = FK_V6;
            min_len = 62;
        end else if (r < 94) begin
            kind    = FK_OTHER;
            min_len = $urandom_range(1, 70);
        end else begin
            kind    = ($urandom_range(0, 1) == 0) ? FK_V4 : FK_V6;
            min_len = $urandom_range(120, 260);
        end
        len = min_len;
        if (r < 80) begin
            len = min_len + $urandom_range(0, 16);
            // one in eight just short of the needed length
            if ($urandom_range(0, 7) == 0) len = min_len - $urandom_range(1, 4);
        end
        if (len < 1) len = 1;
        make_frame(kind, len, ihl, proto, dport);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int n;
        if (gaps_on && $urandom_range(0, 11) == 0) begin
            n = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid   <= 1'b1;
        frame_byte <= b;
        last_byte  <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++) begin
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
        bytes_sent  += frame_buf.size();
        frames_sent += 1;
    endtask

    // hold off the sender until every queued action has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_port(input logic [15:0] v);
        wait_drained();
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid  <= 1'b0;
        target_now = v;
    endtask

    initial begin
        logic [15:0] next_port;
        int          start_bytes;
        int          start_frames;
        int          drain_cycles;
        repeat (8) @(posedge clk);
        rst_n   <= 1'b1;
        gaps_on <= 1'b1;
        @(posedge clk);

        // directed frames at the reset port value
        make_frame(FK_V4, 42, 4'd5, PROTO_UDP, target_now);       send_frame();
        make_frame(FK_V4, 41, 4'd5, PROTO_UDP, target_now);       send_frame();
        make_frame(FK_V4, 60, 4'd5, PROTO_UDP, target_now + 16'd1); send_frame();
        make_frame(FK_V4, 34, 4'd0, PROTO_UDP, target_now);       send_frame();
        make_frame(FK_V4, 33, 4'd0, PROTO_UDP, target_now);       send_frame();
        make_frame(FK_V4, 82, 4'd15, PROTO_UDP, target_now);      send_frame();
        make_frame(FK_V4, 81, 4'd15, PROTO_UDP, target_now);      send_frame();
        make_frame(FK_V4, 50, 4'd5, 8'd6, target_now);            send_frame();
        make_frame(FK_V6, 62, 4'd0, PROTO_UDP, target_now);       send_frame();
        make_frame(FK_V6, 61, 4'd0, PROTO_UDP, target_now);       send_frame();
        make_frame(FK_V6, 70, 4'd0, 8'd6, target_now);            send_frame();
        make_frame(FK_OTHER, 64, 4'd0, PROTO_UDP, target_now);    send_frame();
        make_frame(FK_OTHER, 1, 4'd0, PROTO_UDP, target_now);     send_frame();
        make_frame(FK_V4, 200, 4'd5, PROTO_UDP, target_now);      send_frame();
        make_frame(FK_V6, 130, 4'd0, PROTO_UDP, target_now);      send_frame();

        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       next_port = 16'h0000;
                1:       next_port = 16'hFFFF;
                2:       next_port = 16'($urandom);
                3:       next_port = DEFAULT_PORT;
                default: next_port = 16'h8001;
            endcase
            write_port(next_port);
            gaps_on      <= (p != 2 && p != 4);
            start_bytes  = bytes_sent;
            start_frames = frames_sent;
            while (bytes_sent - start_bytes < 100 || frames_sent - start_frames < 1) begin
                random_frame();
                send_frame();
            end
        end

        in_valid <= 1'b0;
        drain_cycles = 0;
        do begin
            @(negedge clk);
            drain_cycles++;
        end while (pending != 0 && drain_cycles < 5000);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[udp_dest_port_packet_steer.f]
src/udpps_pkg.sv
src/udpps_cfg.sv
src/udpps_parse.sv
src/udpps_out.sv
src/udp_dest_port_packet_steer.sv
sim/udpps_steer_checker.sv
sim/tb_top.sv
